// ===== hw/rtl/b2da_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared widths, types and constants for the binary to decimal ASCII unit.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int VALUE_BITS      = 32;
  // Decimal digits of 2^VALUE_BITS - 1: floor(VALUE_BITS * log10(2)) + 1.
  localparam int DIGITS          = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int DIGIT_IDX_BITS  = $clog2(DIGITS);
  localparam int BCD_BITS        = DIGITS * 4;
  localparam int STEPS_PER_STAGE = 8;
  localparam int NUM_STAGES      = (VALUE_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int PAD_BITS        = NUM_STAGES * STEPS_PER_STAGE;
  localparam int ASCII_BITS      = 6;

  localparam logic [ASCII_BITS-1:0] ASCII_ZERO = ASCII_BITS'(48);

  typedef logic [DIGITS-1:0][3:0]    bcd_t;
  typedef logic [DIGIT_IDX_BITS-1:0] digit_idx_t;

  // Double-dabble working set: BCD accumulator and the binary bits not yet shifted in.
  typedef struct packed {
    bcd_t                bcd;
    logic [PAD_BITS-1:0] bin;
  } dd_t;

endpackage

// ===== hw/rtl/binary_to_decimal_ascii_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit
// Converts an unsigned binary number to its decimal digits in ASCII, most
// significant first, no leading zeros, last digit flagged.
// ----------------------------------------------------------------------------
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------
//   input    | value_valid / value_stall  | value
//   output   | digit_valid / digit_stall  | ascii_digit, is_last
//
// A number with n decimal digits (1 to 10 at 32 bits) occupies the output
// serializer until all n digits have transferred; that serializer sets the
// sustained rate. Conversion is a double-dabble pipeline, 8 shift steps per
// stage, followed by a leading-digit stage and then the output serializer
// register, which drives the digits. Reset clears the valid bits only.
// Stalls propagate back stage by stage; a stage with no item always loads.
//
module binary_to_decimal_ascii_unit
  import b2da_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  value_valid,
  output logic                  value_stall,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  digit_valid,
  input  logic                  digit_stall,
  output logic [ASCII_BITS-1:0] ascii_digit,
  output logic                  is_last
);

  function automatic dd_t dd_steps(dd_t d);
    dd_t             r;
    logic [3:0]      dig;
    logic [BCD_BITS:0] sh;
    r = d;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      for (int i = 0; i < DIGITS; i++) begin
        dig = r.bcd[i];
        if (dig >= 4'd5) begin
          r.bcd[i] = dig + 4'd3;
        end
      end
      sh    = {r.bcd, r.bin[PAD_BITS-1]};
      r.bcd = sh[BCD_BITS-1:0];
      r.bin = {r.bin[PAD_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic digit_idx_t lead_index(bcd_t b);
    digit_idx_t idx;
    idx = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (b[i] != 4'd0) begin
        idx = DIGIT_IDX_BITS'(i);
      end
    end
    return idx;
  endfunction

  // Conversion pipeline
  dd_t                   st     [NUM_STAGES];
  logic [NUM_STAGES-1:0] st_v;
  logic [NUM_STAGES:0]   load;
  dd_t                   st_in  [NUM_STAGES];

  // Leading-digit stage
  logic       lead_v;
  bcd_t       lead_bcd;
  digit_idx_t lead_idx;

  // Output serializer
  logic       ser_v;
  bcd_t       ser_bcd;
  digit_idx_t pos;
  logic       ser_load;
  logic       out_xfer;

  assign out_xfer = ser_v && !digit_stall;
  assign ser_load = !ser_v || (out_xfer && pos == '0);

  always_comb begin
    load[NUM_STAGES] = !lead_v || ser_load;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      load[i] = !st_v[i] || load[i+1];
    end
  end

  assign value_stall = !load[0];

  always_comb begin
    st_in[0] = dd_steps('{bcd: '0, bin: PAD_BITS'(value)});
    for (int i = 1; i < NUM_STAGES; i++) begin
      st_in[i] = dd_steps(st[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_v <= '0;
    end else begin
      if (load[0]) begin
        st_v[0] <= value_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (load[i]) begin
          st_v[i] <= st_v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (load[i]) begin
        st[i] <= st_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_v <= 1'b0;
    end else if (load[NUM_STAGES]) begin
      lead_v <= st_v[NUM_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (load[NUM_STAGES]) begin
      lead_bcd <= st[NUM_STAGES-1].bcd;
      lead_idx <= lead_index(st[NUM_STAGES-1].bcd);
    end
  end

  // Serializer walks from the leading digit down to digit 0.
  always_ff @(posedge clk) begin
    if (rst) begin
      ser_v <= 1'b0;
    end else if (ser_load) begin
      ser_v <= lead_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_bcd <= lead_bcd;
      pos     <= lead_idx;
    end else if (out_xfer) begin
      pos <= pos - 1'b1;
    end
  end

  assign digit_valid = ser_v;
  assign ascii_digit = ASCII_ZERO + ASCII_BITS'(ser_bcd[pos]);
  assign is_last     = (pos == '0);

`ifndef SYNTHESIS
  a_lead_nonzero: assert property (@(posedge clk) disable iff (rst)
    lead_v && lead_idx != '0 |-> lead_bcd[lead_idx] != 4'd0)
    else $error("leading digit is zero");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    digit_valid |-> ascii_digit >= ASCII_ZERO && ascii_digit <= ASCII_ZERO + 6'd9)
    else $error("output digit out of range");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    ser_v |-> 32'(pos) < DIGITS)
    else $error("digit position out of range");

  a_step_down: assert property (@(posedge clk) disable iff (rst)
    out_xfer && !is_last |=> digit_valid && pos == $past(pos) - 1'b1)
    else $error("serializer skipped a digit");
`endif

endmodule

// ===== verif/binary_to_decimal_ascii_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit_tb
// Feeds directed and random 32-bit numbers to the converter. A local model
// queues the expected ASCII digits with their last-digit flags, and every
// output transfer is checked against it. Sender gaps and receiver stalls
// vary by phase, and one long receiver hold backs the pipeline up.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_unit_tb
  import b2da_pkg::*;
();

  localparam int RUN_LIMIT = 200000;
  localparam int LONG_HOLD = 300;

  typedef struct {
    logic [ASCII_BITS-1:0] code;
    logic                  last;
  } ascii_char_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  value_valid = 1'b0;
  logic                  value_stall;
  logic [VALUE_BITS-1:0] value = '0;
  logic                  digit_valid;
  logic                  digit_stall = 1'b0;
  logic [ASCII_BITS-1:0] ascii_digit;
  logic                  is_last;

  ascii_char_t pending_digits[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  int          hold_req = 0;
  int          hold_seen = 0;

  binary_to_decimal_ascii_unit dut (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value),
    .digit_valid (digit_valid),
    .digit_stall (digit_stall),
    .ascii_digit (ascii_digit),
    .is_last     (is_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: a long hold takes priority over random stalls.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= LONG_HOLD - 1;
      digit_stall <= 1'b1;
    end else if (hold_left > 0) begin
      digit_stall <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      digit_stall <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH @%0t %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : digit_check
    ascii_char_t want;
    if (!rst && digit_valid && !digit_stall) begin
      if (pending_digits.size() == 0) begin
        report_mismatch("digit with none pending", ascii_digit, 0);
      end else begin
        want = pending_digits.pop_front();
        if (ascii_digit !== want.code)
          report_mismatch("ascii_digit", ascii_digit, want.code);
        if (is_last !== want.last)
          report_mismatch("is_last", is_last, want.last);
      end
    end
  end

  // Decimal digits, most significant first, no leading zeros.
  task automatic queue_decimal_digits(input logic [VALUE_BITS-1:0] v);
    logic [3:0]      digits[$];
    longint unsigned rest;
    ascii_char_t     c;
    rest = v;
    do begin
      digits.push_front(4'(rest % 10));
      rest = rest / 10;
    end while (rest != 0);
    foreach (digits[k]) begin
      c.code = ASCII_BITS'(ASCII_ZERO + digits[k]);
      c.last = (k == digits.size() - 1);
      pending_digits.push_back(c);
    end
  endtask

  task automatic send_number(input logic [VALUE_BITS-1:0] v);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      value_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
    value_valid <= 1'b1;
    value       <= v;
    @(posedge clk);
    while (value_stall) @(posedge clk);
    queue_decimal_digits(v);
  endtask

  // Sender stops and waits for every pending digit.
  task automatic wait_all_digits();
    value_valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Digit count picked first so short numbers are as common as long ones.
  function automatic logic [VALUE_BITS-1:0] random_number();
    int unsigned     len;
    longint unsigned span;
    len = $urandom_range(10, 1);
    if (len == 10) return $urandom_range(32'hFFFF_FFFF, 32'd1_000_000_000);
    span = 1;
    repeat (len) span = span * 10;
    return VALUE_BITS'($urandom % span);
  endfunction

  task automatic test_directed();
    logic [VALUE_BITS-1:0] picks[$];
    picks = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
              32'd10000, 32'd99999, 32'd100000, 32'd1000000, 32'd9999999,
              32'd10000000, 32'd100000000, 32'd999999999, 32'd1000000000,
              32'd1234567890, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000,
              32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd4000000000};
    send_idle_pct = 0;
    stall_pct     = 0;
    foreach (picks[i]) send_number(picks[i]);
    wait_all_digits();
  endtask

  task automatic test_random(input int count, input int idle_pct, input int stall_rate);
    send_idle_pct = idle_pct;
    stall_pct     = stall_rate;
    repeat (count) send_number(random_number());
    wait_all_digits();
  endtask

  // Receiver holds off while the sender keeps offering; input must back up.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req     <= hold_req + 1;
    repeat (40) send_number(random_number());
    wait_all_digits();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(50, 0, 0);
    test_random(50, 80, 0);
    test_random(50, 0, 80);
    test_random(50, 16, 16);
    test_backpressure();
    repeat (NUM_STAGES + 20) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/b2da_pkg.sv
hw/rtl/binary_to_decimal_ascii_unit.sv
verif/binary_to_decimal_ascii_unit_tb.sv
